/* hdl/packed_bcd_field_decoder_assert.svh */
// assertion helpers for the decoder back part
`ifndef PACKED_BCD_FIELD_DECODER_ASSERT_SVH
`define PACKED_BCD_FIELD_DECODER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define PBCD_ASSERT_NOW(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define PBCD_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error(msg);

`endif

/* hdl/pbcd_pkg.sv */
package pbcd_pkg;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_DIGIT = 3'd1;
    localparam logic [2:0] ST_OVERFLOW  = 3'd2;
    localparam logic [2:0] ST_BAD_LEN   = 3'd3;
    localparam logic [2:0] ST_BAD_TIME  = 3'd4;

    localparam logic [3:0] TIME_BYTES = 4'd6;
    localparam logic [3:0] COUNT_MAX  = 4'd15;
    localparam logic [3:0] DIGIT_MAX  = 4'd9;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [6:0] HOUR_MAX = 7'd23;
    localparam logic [6:0] MINSEC_MAX = 7'd59;
    localparam logic [46:0] NS_PER_SEC = 47'd1000000000;
    localparam logic [29:0] NS_PER_US  = 30'd1000;

    // one classified byte as it travels from front to back
    typedef struct packed {
        logic [3:0] hi;
        logic [3:0] lo;
        logic [6:0] pair;
        logic       bad;
        logic       last;
        logic       is_time;
    } pbcd_item_t;

endpackage

/* hdl/pbcd_front.sv */
module pbcd_front (
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         bcd_byte,
    input  logic               last,
    input  logic               time_field,
    output logic               push,
    output pbcd_pkg::pbcd_item_t push_item,
    input  logic               queue_full
);
    import pbcd_pkg::*;

    logic [3:0] hi;
    logic [3:0] lo;

    assign hi = bcd_byte[7:4];
    assign lo = bcd_byte[3:0];

    assign in_stall = queue_full;
    assign push     = in_valid;

    // digit check and pair value hi*10+lo
    always_comb
    begin
        push_item.hi      = hi;
        push_item.lo      = lo;
        push_item.pair    = ({3'd0, hi} << 3) + ({3'd0, hi} << 1) + {3'd0, lo};
        push_item.bad     = (hi > DIGIT_MAX) || (lo > DIGIT_MAX);
        push_item.last    = last;
        push_item.is_time = time_field;
    end

endmodule

/* hdl/pbcd_queue.sv */
module pbcd_queue #(
    parameter int DEPTH = pbcd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  pbcd_pkg::pbcd_item_t push_item,
    output logic                 full,
    output logic                 pop_valid,
    output pbcd_pkg::pbcd_item_t pop_item,
    input  logic                 pop
);
    import pbcd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    pbcd_item_t       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign pop_valid = (count_reg != '0);
    assign pop_item  = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* hdl/pbcd_back.sv */
`include "packed_bcd_field_decoder_assert.svh"

module pbcd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  pbcd_pkg::pbcd_item_t q_item,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [63:0]          value,
    output logic [2:0]           status
);
    import pbcd_pkg::*;

    typedef enum logic [1:0] {
        BK_ACCUM,
        BK_TIME_RANGE,
        BK_TIME_MUL,
        BK_TIME_SUM
    } back_state_t;

    back_state_t state_reg, state_next;
    logic [63:0] acc_reg, acc_next;
    logic [3:0]  count_reg, count_next;
    logic [2:0]  err_reg, err_next;
    // digits of a time field, captured by byte position
    logic [6:0]  hh_reg, hh_next;
    logic [6:0]  mi_reg, mi_next;
    logic [6:0]  ss_reg, ss_next;
    logic [6:0]  p3_reg, p3_next;
    logic [3:0]  n4h_reg, n4h_next;
    logic [3:0]  n4l_reg, n4l_next;
    logic [6:0]  p5_reg, p5_next;
    logic        range_bad_reg, range_bad_next;
    logic [16:0] secs_reg, secs_next;
    logic [19:0] micro_reg, micro_next;
    logic [46:0] ns_sec_reg, ns_sec_next;
    logic [29:0] ns_sub_reg, ns_sub_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] value_reg, value_next;
    logic [2:0]  status_reg, status_next;

    logic        out_free;
    logic [3:0]  cnt_sat;
    logic [70:0] mul100;
    logic [63:0] upd_acc;
    logic [2:0]  upd_err;
    logic [18:0] secs_wide;
    logic [19:0] micro_wide;
    logic [46:0] ns_total;

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

    // byte update: acc*100 + pair with overflow test on the top bits
    always_comb
    begin
        cnt_sat = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 4'd1;
        mul100  = ({7'd0, acc_reg} << 6) + ({7'd0, acc_reg} << 5)
                + ({7'd0, acc_reg} << 2) + {64'd0, q_item.pair};
        upd_acc = acc_reg;
        upd_err = err_reg;
        if (err_reg == ST_OK)
        begin
            if (q_item.bad)
            begin
                upd_err = ST_BAD_DIGIT;
            end
            else if (mul100[70:64] != 7'd0)
            begin
                upd_err = ST_OVERFLOW;
            end
            else
            begin
                upd_acc = mul100[63:0];
            end
        end
    end

    always_comb
    begin
        secs_wide  = 19'(hh_reg) * 19'd3600 + 19'(mi_reg) * 19'd60 + 19'(ss_reg);
        micro_wide = 20'(p3_reg) * 20'd10000 + 20'(n4h_reg) * 20'd1000
                   + 20'(n4l_reg) * 20'd100 + 20'(p5_reg);
        ns_total   = ns_sec_reg + {17'd0, ns_sub_reg};
    end

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        count_next     = count_reg;
        err_next       = err_reg;
        hh_next        = hh_reg;
        mi_next        = mi_reg;
        ss_next        = ss_reg;
        p3_next        = p3_reg;
        n4h_next       = n4h_reg;
        n4l_next       = n4l_reg;
        p5_next        = p5_reg;
        range_bad_next = range_bad_reg;
        secs_next      = secs_reg;
        micro_next     = micro_reg;
        ns_sec_next    = ns_sec_reg;
        ns_sub_next    = ns_sub_reg;
        out_valid_next = out_valid_reg && out_stall;
        value_next     = value_reg;
        status_next    = status_reg;
        q_pop          = 1'b0;

        unique case (state_reg)
            BK_ACCUM:
            begin
                if (q_valid && (!q_item.last || out_free))
                begin
                    q_pop      = 1'b1;
                    acc_next   = upd_acc;
                    count_next = cnt_sat;
                    err_next   = upd_err;
                    case (count_reg)
                        4'd0: hh_next = q_item.pair;
                        4'd1: mi_next = q_item.pair;
                        4'd2: ss_next = q_item.pair;
                        4'd3: p3_next = q_item.pair;
                        4'd4:
                        begin
                            n4h_next = q_item.hi;
                            n4l_next = q_item.lo;
                        end
                        4'd5: p5_next = q_item.pair;
                        default: ;
                    endcase
                    if (q_item.last)
                    begin
                        acc_next   = '0;
                        count_next = '0;
                        err_next   = ST_OK;
                        if (q_item.is_time)
                        begin
                            if (cnt_sat != TIME_BYTES)
                            begin
                                out_valid_next = 1'b1;
                                value_next     = '0;
                                status_next    = ST_BAD_LEN;
                            end
                            else if (upd_err != ST_OK)
                            begin
                                out_valid_next = 1'b1;
                                value_next     = '0;
                                status_next    = upd_err;
                            end
                            else
                            begin
                                state_next = BK_TIME_RANGE;
                            end
                        end
                        else
                        begin
                            out_valid_next = 1'b1;
                            value_next     = (upd_err == ST_OK) ? upd_acc : '0;
                            status_next    = upd_err;
                        end
                    end
                end
            end
            BK_TIME_RANGE:
            begin
                range_bad_next = (hh_reg > HOUR_MAX) || (mi_reg > MINSEC_MAX)
                               || (ss_reg > MINSEC_MAX);
                secs_next      = secs_wide[16:0];
                micro_next     = micro_wide;
                state_next     = BK_TIME_MUL;
            end
            BK_TIME_MUL:
            begin
                ns_sec_next = {30'd0, secs_reg} * NS_PER_SEC;
                ns_sub_next = {10'd0, micro_reg} * NS_PER_US;
                state_next  = BK_TIME_SUM;
            end
            BK_TIME_SUM:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    value_next     = range_bad_reg ? 64'd0 : {17'd0, ns_total};
                    status_next    = range_bad_reg ? ST_BAD_TIME : ST_OK;
                    state_next     = BK_ACCUM;
                end
            end
            default:
            begin
                state_next = BK_ACCUM;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_ACCUM;
            acc_reg       <= '0;
            count_reg     <= '0;
            err_reg       <= ST_OK;
            hh_reg        <= '0;
            mi_reg        <= '0;
            ss_reg        <= '0;
            p3_reg        <= '0;
            n4h_reg       <= '0;
            n4l_reg       <= '0;
            p5_reg        <= '0;
            range_bad_reg <= 1'b0;
            secs_reg      <= '0;
            micro_reg     <= '0;
            ns_sec_reg    <= '0;
            ns_sub_reg    <= '0;
            out_valid_reg <= 1'b0;
            value_reg     <= '0;
            status_reg    <= ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            count_reg     <= count_next;
            err_reg       <= err_next;
            hh_reg        <= hh_next;
            mi_reg        <= mi_next;
            ss_reg        <= ss_next;
            p3_reg        <= p3_next;
            n4h_reg       <= n4h_next;
            n4l_reg       <= n4l_next;
            p5_reg        <= p5_next;
            range_bad_reg <= range_bad_next;
            secs_reg      <= secs_next;
            micro_reg     <= micro_next;
            ns_sec_reg    <= ns_sec_next;
            ns_sub_reg    <= ns_sub_next;
            out_valid_reg <= out_valid_next;
            value_reg     <= value_next;
            status_reg    <= status_next;
        end
    end

    `PBCD_ASSERT_NOW(a_err_zero_value, clk, rst_n, out_valid_reg && (status_reg != ST_OK),
        value_reg == 64'd0, "error result carries a nonzero value")
    `PBCD_ASSERT_NOW(a_no_pop_in_time, clk, rst_n, state_reg != BK_ACCUM, !q_pop,
        "queue popped during time conversion")
    `PBCD_ASSERT_NEXT(a_field_cleared, clk, rst_n, q_pop && q_item.last,
        (count_reg == 4'd0) && (err_reg == ST_OK) && (acc_reg == 64'd0),
        "field state not cleared after last byte")
    `PBCD_ASSERT_NEXT(a_time_seq, clk, rst_n, state_reg == BK_TIME_RANGE,
        state_reg == BK_TIME_MUL, "time sequence skipped a step")

endmodule

/* hdl/packed_bcd_field_decoder.sv */
// packed bcd field decoder: bytes of a packed bcd field come in one item per cycle while
// in_stall is low, two digits per byte with the high nibble first, and the byte carrying
// last closes the field with exactly one result (value, status). status 0 ok, 1 bad digit,
// 2 overflow past 64 bits, 3 bad time length, 4 time out of range; value is 0 whenever
// status is not 0. with time_field set on the last byte the field must be six bytes hh mm
// ss mmm uuu and the value is nanoseconds since midnight. rate: one byte per cycle, set by
// the back part taking one queued byte each cycle (one 64-bit times-100 add and overflow
// compare) except during time conversion or while a last byte waits on a busy output;
// a time field's last byte is followed by a range check, multiply and final add while the
// queue of QUEUE_DEPTH items keeps absorbing input. a result is registered as its last byte
// leaves the queue or at the final add; other bytes still flow while it waits on out_stall.
module packed_bcd_field_decoder #(
    parameter int QUEUE_DEPTH = pbcd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  bcd_byte,
    input  logic        last,
    input  logic        time_field,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] value,
    output logic [2:0]  status
);
    import pbcd_pkg::*;

    // classified item from front into the queue
    pbcd_item_t push_item;
    logic       push;
    logic       queue_full;

    // head of the queue towards the back part
    pbcd_item_t head_item;
    logic       head_valid;
    logic       head_pop;

    // front: digit check and pair value, stalls only when the queue is full
    pbcd_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .bcd_byte   (bcd_byte),
        .last       (last),
        .time_field (time_field),
        .push       (push),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    // short queue decoupling the two sides
    pbcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop_valid (head_valid),
        .pop_item  (head_item),
        .pop       (head_pop)
    );

    // back: accumulation, sticky error, time conversion and the output register
    pbcd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (head_valid),
        .q_item    (head_item),
        .q_pop     (head_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .status    (status)
    );

endmodule
